### rtl/core/mmr_pkg.sv
// Shared types, constants and microcode table for the row-range matrix multiplier.
`timescale 1ns / 1ps

package mmr_pkg;

    // Stream payload widths (byte aligned)
    localparam int InDataW  = 40;
    localparam int OutDataW = 72;
    localparam int ActionW  = 2;
    // Row counter covers first row plus row count (up to 3 + 7)
    localparam int RowCntW  = 4;

    typedef enum logic [ActionW-1:0] {
        ACT_LOAD_LEFT  = 2'd0,
        ACT_LOAD_RIGHT = 2'd1,
        ACT_COMPUTE    = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_ROW     = 3'd1,
        S_READ    = 3'd2,
        S_WAIT1   = 3'd3,
        S_WAIT2   = 3'd4,
        S_EMIT    = 3'd5,
        S_ADVANCE = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        UOP_NOP     = 3'd0,
        UOP_ACCEPT  = 3'd1,
        UOP_CLEAR   = 3'd2,
        UOP_READ    = 3'd3,
        UOP_EMIT    = 3'd4,
        UOP_ADVANCE = 3'd5
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_START = 3'd2,
        C_ROW_DONE = 3'd3,
        C_K_MORE   = 3'd4,
        C_OUT_BUSY = 3'd5
    } cond_t;

    // One control word: operation, jump condition, jump target, fall-through step
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
        step_t next;
    } ctrl_word_t;

    localparam int NumSteps = 7;

    localparam ctrl_word_t Ucode [NumSteps] = '{
        '{op: UOP_ACCEPT,  cond: C_NO_START, target: S_IDLE,  next: S_ROW},
        '{op: UOP_CLEAR,   cond: C_ROW_DONE, target: S_IDLE,  next: S_READ},
        '{op: UOP_READ,    cond: C_K_MORE,   target: S_READ,  next: S_WAIT1},
        '{op: UOP_NOP,     cond: C_NEVER,    target: S_IDLE,  next: S_WAIT2},
        '{op: UOP_NOP,     cond: C_NEVER,    target: S_IDLE,  next: S_EMIT},
        '{op: UOP_EMIT,    cond: C_OUT_BUSY, target: S_EMIT,  next: S_ADVANCE},
        '{op: UOP_ADVANCE, cond: C_ALWAYS,   target: S_ROW,   next: S_ROW}
    };

endpackage

### rtl/core/matrix_multiply_rows.sv
// Microcoded integer matrix multiplier emitting product elements over a row range.
// Load items leave the sequencer idle; the input is ready only while the sequencer is idle.
// A compute item runs, per result, the steps row (clear), read (the single multiply-accumulate
// unit fed one element pair per cycle from the two matrix memories), wait1, wait2, emit (held
// while the output register is busy) and advance. The output register lets a new item in.
// Reset clears the sequencer and output valid; matrix contents are not cleared.
`timescale 1ns / 1ps

module matrix_multiply_rows #(
    parameter int SIZE          = 4,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row[1:0], col[3:2], value[35:4], row_count[38:36], zero pad
    input  logic [mmr_pkg::InDataW-1:0]   s_axis_tdata,
    // action
    input  logic [mmr_pkg::ActionW-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_row[1:0], out_col[3:2], product[67:4], zero pad
    output logic [mmr_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast
);

    import mmr_pkg::*;

    localparam int IW = $clog2(SIZE);
    localparam int AW = $clog2(SIZE * SIZE);
    localparam int EW = ELEMENT_WIDTH;
    localparam logic [IW-1:0] KLast = IW'(SIZE - 1);

    // Sequencer
    step_t      pc_reg, pc_next;
    ctrl_word_t uw;
    logic       cond_true;

    // Loop counters
    logic [RowCntW-1:0] row_reg, end_reg;
    logic [IW-1:0]      col_reg, k_reg;

    // Multiply-accumulate pipeline
    logic                        rdv_reg, mulv_reg;
    logic signed [EW-1:0]        left_q_reg, right_q_reg;
    logic signed [2*EW-1:0]      prod_reg;
    logic signed [63:0]          acc_reg;

    // Output register
    logic         out_valid_reg;
    logic [1:0]   out_row_reg, out_col_reg;
    logic [63:0]  out_prod_reg;
    logic         out_last_reg;

    // Matrix memories
    logic [EW-1:0] left_mem  [SIZE*SIZE];
    logic [EW-1:0] right_mem [SIZE*SIZE];

    logic [1:0]  in_row, in_col;
    logic [31:0] in_value;
    logic [2:0]  in_count;
    logic        in_accept, is_compute, in_range, we_left, we_right;
    logic [AW-1:0] wr_addr, rd_addr_l, rd_addr_r;
    logic        row_done, out_free, emit, last_next;

    assign in_row   = s_axis_tdata[1:0];
    assign in_col   = s_axis_tdata[3:2];
    assign in_value = s_axis_tdata[35:4];
    assign in_count = s_axis_tdata[38:36];

    assign uw            = Ucode[pc_reg];
    assign s_axis_tready = (uw.op == UOP_ACCEPT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_compute    = in_accept && (s_axis_tuser == ACT_COMPUTE);
    assign in_range      = (32'(in_row) < SIZE) && (32'(in_col) < SIZE);
    assign we_left       = in_accept && (s_axis_tuser == ACT_LOAD_LEFT) && in_range;
    assign we_right      = in_accept && (s_axis_tuser == ACT_LOAD_RIGHT) && in_range;
    assign wr_addr       = AW'(32'(in_row) * SIZE + 32'(in_col));
    assign rd_addr_l     = AW'(32'(row_reg) * SIZE + 32'(k_reg));
    assign rd_addr_r     = AW'(32'(k_reg) * SIZE + 32'(col_reg));

    assign row_done  = (32'(row_reg) >= SIZE) || (row_reg >= end_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit      = (uw.op == UOP_EMIT) && out_free;
    // last result: final column and the next row is out of range
    assign last_next = (col_reg == KLast) &&
                       ((32'(row_reg) + 1 >= SIZE) || (row_reg + RowCntW'(1) >= end_reg));

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_START: cond_true = !is_compute;
            C_ROW_DONE: cond_true = row_done;
            C_K_MORE:   cond_true = (k_reg != KLast);
            C_OUT_BUSY: cond_true = !out_free;
            default:    cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.target : uw.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (we_left)
        begin
            left_mem[wr_addr] <= in_value[EW-1:0];
        end
        left_q_reg <= left_mem[rd_addr_l];
    end

    always_ff @(posedge clk)
    begin
        if (we_right)
        begin
            right_mem[wr_addr] <= in_value[EW-1:0];
        end
        right_q_reg <= right_mem[rd_addr_r];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            end_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            rdv_reg       <= 1'b0;
            mulv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rdv_reg  <= (uw.op == UOP_READ);
            mulv_reg <= rdv_reg;
            if (is_compute)
            begin
                row_reg <= RowCntW'(in_row);
                end_reg <= RowCntW'(in_row) + RowCntW'(in_count);
                col_reg <= '0;
            end
            if (uw.op == UOP_CLEAR)
            begin
                k_reg <= '0;
            end
            if (uw.op == UOP_READ)
            begin
                k_reg <= k_reg + IW'(1);
            end
            if (uw.op == UOP_ADVANCE)
            begin
                if (col_reg == KLast)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RowCntW'(1);
                end
                else
                begin
                    col_reg <= col_reg + IW'(1);
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            prod_reg <= left_q_reg * right_q_reg;
        end
        if (uw.op == UOP_CLEAR)
        begin
            acc_reg <= '0;
        end
        else if (mulv_reg)
        begin
            acc_reg <= acc_reg + 64'(prod_reg);
        end
        if (emit)
        begin
            out_row_reg  <= 2'(row_reg);
            out_col_reg  <= 2'(col_reg);
            out_prod_reg <= acc_reg;
            out_last_reg <= last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_prod_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    // The MAC pipeline must be drained before a result is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_EMIT) |-> (!rdv_reg && !mulv_reg))
        else $error("result taken before accumulation finished");

    // Matrix reads only happen for rows inside the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_READ) |-> (32'(row_reg) < SIZE))
        else $error("read issued for a row past the matrix");

    // Column counter stays inside the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < SIZE)
        else $error("column counter out of range");

    // A result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg) |-> m_axis_tready)
        else $error("output register overwritten while held");

endmodule
